### sv/sketch_bitmap_rank_store_assert.svh
// ---------------------------------------------------------------------------
// Assertion helpers for the sketch bitmap rank store
// ---------------------------------------------------------------------------
`ifndef SKETCH_BITMAP_RANK_STORE_ASSERT_SVH
`define SKETCH_BITMAP_RANK_STORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SBRS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SBRS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sbrs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbrs_pkg
// Types and fixed constants shared by the sketch bitmap rank store.
// ---------------------------------------------------------------------------
package sbrs_pkg;

  // Fixed field widths
  localparam int unsigned SKETCH_IDX_W = 8;
  localparam int unsigned BIT_IDX_W    = 6;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned CFG_W        = 9;
  // Wide enough to compare a sketch index against a store depth of up to 8191
  localparam int unsigned IDX_CMP_W    = 13;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // Opcodes
  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_SET   = 1'b1
  } sbrs_op_e;

  typedef struct packed {
    logic                    opcode;
    logic [SKETCH_IDX_W-1:0] sketch_index;
    logic [BIT_IDX_W-1:0]    bit_index;
  } sbrs_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] trailing_zeros;
    logic [COUNT_W-1:0] leading_ones;
    logic               index_error;
  } sbrs_out_t;

endpackage

### sv/sbrs_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbrs_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ---------------------------------------------------------------------------
module sbrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sketch_bitmap_rank_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sketch_bitmap_rank_store
// Store of probabilistic-counting sketch bitmaps with rank queries.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one item: an
//   opcode, a sketch index and a bit index. Query reads the sketch, set ORs
//   in one bit first. Each item returns one result on the output channel
//   (out_valid_o/out_ready_i/out_data_o): trailing zeros and leading ones of
//   the sketch after the update, or an index error with both counts zero.
//   The config channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the
//   number of sketches in use; write it only while no item is in flight.
//   From accept to result an item passes the read stage, where the store is
//   read, and the result register, loaded after merge, write-back and
//   counting. Throughput is one item per cycle while the receiver takes
//   results, set by the single read-modify-write on the store with the last
//   written word forwarded to the next item. After reset the store is swept
//   to zero, one word per cycle; in_ready_o stays low meanwhile.
//   When the receiver stalls, the result register holds and one further
//   item may be taken into the read stage before in_ready_o drops.
// ---------------------------------------------------------------------------
module sketch_bitmap_rank_store #(
  parameter int unsigned SKETCH_BITS  = 32,
  parameter int unsigned NUM_SKETCHES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sbrs_pkg::sbrs_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sbrs_pkg::sbrs_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sbrs_pkg::CFG_W-1:0]      cfg_data_i
);
  import sbrs_pkg::*;

  `include "sketch_bitmap_rank_store_assert.svh"

  localparam int unsigned AW = (NUM_SKETCHES > 1) ? $clog2(NUM_SKETCHES) : 1;
  localparam int unsigned XW = (AW > SKETCH_IDX_W) ? AW : SKETCH_IDX_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SKETCHES - 1);

  // Rightmost one position, SKETCH_BITS when empty
  function automatic logic [COUNT_W-1:0] low_zeros(input logic [SKETCH_BITS-1:0] w);
    logic [COUNT_W-1:0] n;
    n = COUNT_W'(SKETCH_BITS);
    for (int i = SKETCH_BITS - 1; i >= 0; i--) begin
      if (w[i]) n = COUNT_W'(i);
    end
    return n;
  endfunction

  // Ones above the leftmost zero, SKETCH_BITS when full
  function automatic logic [COUNT_W-1:0] high_ones(input logic [SKETCH_BITS-1:0] w);
    logic [COUNT_W-1:0] n;
    n = COUNT_W'(SKETCH_BITS);
    for (int i = 0; i < SKETCH_BITS; i++) begin
      if (!w[i]) n = COUNT_W'(SKETCH_BITS - 1 - i);
    end
    return n;
  endfunction

  logic [CFG_W-1:0]       in_use_q;
  logic                   clr_active_q, clr_active_d;
  logic [AW-1:0]          clr_addr_q, clr_addr_d;

  logic                   s1_valid_q, s1_valid_d;
  logic                   s1_op_q;
  logic [AW-1:0]          s1_addr_q;
  logic [BIT_IDX_W-1:0]   s1_bit_q;
  logic                   s1_err_q;

  logic                   fwd_valid_q, fwd_valid_d;
  logic [AW-1:0]          fwd_addr_q;
  logic [SKETCH_BITS-1:0] fwd_data_q;

  logic                   out_valid_q, out_valid_d;
  sbrs_out_t              out_q;

  logic                   adv;
  logic                   load;
  logic                   accept;
  logic                   in_err;
  logic [XW-1:0]          in_idx_ext;
  logic [AW-1:0]          in_addr;
  logic [SKETCH_BITS-1:0] ram_rdata;
  logic [SKETCH_BITS-1:0] merged_word;
  logic [SKETCH_BITS-1:0] new_word;
  logic                   item_we;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SKETCH_BITS-1:0] ram_wdata;

  // Handshake and stage control
  assign adv         = !out_valid_q || out_ready_i;
  assign load        = adv || !s1_valid_q;
  assign in_ready_o  = !clr_active_q && load;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Range checks on the incoming item
  assign in_idx_ext = XW'(in_data_i.sketch_index);
  assign in_addr    = in_idx_ext[AW-1:0];
  assign in_err = ({1'b0, in_data_i.sketch_index} >= in_use_q)
               || (IDX_CMP_W'(in_data_i.sketch_index) >= IDX_CMP_W'(NUM_SKETCHES))
               || ((in_data_i.opcode == OP_SET)
                   && (COUNT_W'(in_data_i.bit_index) >= COUNT_W'(SKETCH_BITS)));

  // Merge stored word with the last write, then set the bit on a set item
  always_comb begin
    merged_word = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;
    new_word    = merged_word;
    if (s1_op_q == OP_SET) begin
      new_word = merged_word | (SKETCH_BITS'(1) << s1_bit_q);
    end
  end

  assign item_we = adv && s1_valid_q && !s1_err_q && (s1_op_q == OP_SET);

  // Store write port: clearing sweep or item write-back
  always_comb begin
    ram_we    = item_we;
    ram_waddr = s1_addr_q;
    ram_wdata = new_word;
    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end
  end

  sbrs_ram #(
    .WIDTH (SKETCH_BITS),
    .DEPTH (NUM_SKETCHES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // Next-state for control
  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == LAST_ADDR) begin
        clr_active_d = 1'b0;
      end
    end
    s1_valid_d  = load ? accept : s1_valid_q;
    out_valid_d = adv ? s1_valid_q : out_valid_q;
    fwd_valid_d = fwd_valid_q || item_we;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q     <= CFG_RESET;
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      fwd_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        in_use_q <= cfg_data_i;
      end
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      fwd_valid_q  <= fwd_valid_d;
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= in_data_i.opcode;
      s1_addr_q <= in_addr;
      s1_bit_q  <= in_data_i.bit_index;
      s1_err_q  <= in_err;
    end
  end

  // Hold the last written word for the next item
  always_ff @(posedge clk_i) begin
    if (item_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_word;
    end
  end

  // Result register: count and report
  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      if (s1_err_q) begin
        out_q.trailing_zeros <= '0;
        out_q.leading_ones   <= '0;
        out_q.index_error    <= 1'b1;
      end else begin
        out_q.trailing_zeros <= low_zeros(new_word);
        out_q.leading_ones   <= high_ones(new_word);
        out_q.index_error    <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `SBRS_ASSERT_NXT(a_clear_once, clk_i, rst_ni, !clr_active_q, !clr_active_q,
                   "store clearing restarted")
  `SBRS_ASSERT_NXT(a_accept_loads, clk_i, rst_ni, accept, s1_valid_q,
                   "accepted item lost before read stage")
  `SBRS_ASSERT_NXT(a_stage_moves, clk_i, rst_ni, s1_valid_q && adv, out_valid_o,
                   "read stage item did not reach the result register")
  `SBRS_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.index_error,
                   (out_data_o.trailing_zeros == '0) && (out_data_o.leading_ones == '0),
                   "error result carries non-zero counts")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the sketch bitmap rank store.
// ---------------------------------------------------------------------------
// Drives set and query items into the store and predicts each result from
// a local copy of the sketch words and of the sketches-in-use limit. It
// checks every result in order against the predicted ranks. The run covers
// directed edge cases and limit settings, full sketches filled in shuffled
// order, and random traffic under several idle and stall patterns.
// ---------------------------------------------------------------------------
module tb;
  import sbrs_pkg::*;

  localparam int unsigned SKETCH_BITS  = 32;
  localparam int unsigned NUM_SKETCHES = 256;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  sbrs_in_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  sbrs_out_t        out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  // Local copy of the block's state
  logic [SKETCH_BITS-1:0] sketch_words [NUM_SKETCHES];
  logic [CFG_W-1:0]       sketch_limit = CFG_RESET;
  sbrs_out_t              expected_ranks [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  logic [SKETCH_IDX_W-1:0] hot_sketch [2];

  sketch_bitmap_rank_store #(
    .SKETCH_BITS  (SKETCH_BITS),
    .NUM_SKETCHES (NUM_SKETCHES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [COUNT_W-1:0] zeros_below_lowest(logic [SKETCH_BITS-1:0] w);
    int unsigned n;
    n = 0;
    while (n < SKETCH_BITS && w[n] == 1'b0) n++;
    return COUNT_W'(n);
  endfunction

  function automatic logic [COUNT_W-1:0] ones_above_highest(logic [SKETCH_BITS-1:0] w);
    int unsigned n;
    n = 0;
    while (n < SKETCH_BITS && w[SKETCH_BITS-1-n] == 1'b1) n++;
    return COUNT_W'(n);
  endfunction

  // Apply one item to the local store and return the ranks it yields
  function automatic sbrs_out_t rank_after_update(sbrs_in_t item);
    sbrs_out_t res;
    logic      reject;
    res    = '0;
    reject = (item.sketch_index >= sketch_limit) ||
             (item.sketch_index >= NUM_SKETCHES) ||
             (item.opcode == OP_SET && item.bit_index >= SKETCH_BITS);
    if (reject) begin
      res.index_error = 1'b1;
    end else begin
      if (item.opcode == OP_SET) begin
        sketch_words[item.sketch_index][item.bit_index] = 1'b1;
      end
      res.trailing_zeros = zeros_below_lowest(sketch_words[item.sketch_index]);
      res.leading_ones   = ones_above_highest(sketch_words[item.sketch_index]);
    end
    return res;
  endfunction

  // Predict on every accepted item, track every register write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        sketch_limit = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        expected_ranks.push_back(rank_after_update(in_data_i));
      end
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin
    sbrs_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ranks.size() == 0) begin
        $error("unexpected result: trailing_zeros %0d leading_ones %0d index_error %0d",
               out_data_o.trailing_zeros, out_data_o.leading_ones, out_data_o.index_error);
        error_count++;
      end else begin
        want = expected_ranks.pop_front();
        if (out_data_o.trailing_zeros !== want.trailing_zeros) begin
          $error("trailing_zeros: expected %0d, actual %0d",
                 want.trailing_zeros, out_data_o.trailing_zeros);
          error_count++;
        end
        if (out_data_o.leading_ones !== want.leading_ones) begin
          $error("leading_ones: expected %0d, actual %0d",
                 want.leading_ones, out_data_o.leading_ones);
          error_count++;
        end
        if (out_data_o.index_error !== want.index_error) begin
          $error("index_error: expected %0d, actual %0d",
                 want.index_error, out_data_o.index_error);
          error_count++;
        end
      end
    end
  end

  function automatic sbrs_in_t make_item(sbrs_op_e op, int unsigned sk, int unsigned bt);
    sbrs_in_t item;
    item.opcode       = op;
    item.sketch_index = SKETCH_IDX_W'(sk);
    item.bit_index    = BIT_IDX_W'(bt);
    return item;
  endfunction

  // Send one item, with a random idle gap in front of it
  task automatic send_item(input sbrs_in_t item);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_sketch_limit(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Empty and partial sketches, top and bottom bits, bad bit indices
  task automatic test_directed_edges();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(make_item(OP_QUERY, 0, 0));
    send_item(make_item(OP_QUERY, 255, 63));
    send_item(make_item(OP_SET, 0, 0));
    send_item(make_item(OP_SET, 0, 31));
    send_item(make_item(OP_SET, 255, 31));
    send_item(make_item(OP_SET, 255, 32));
    send_item(make_item(OP_SET, 255, 63));
    send_item(make_item(OP_QUERY, 255, 32));
    send_item(make_item(OP_SET, 128, 30));
    send_item(make_item(OP_SET, 128, 31));
    send_item(make_item(OP_SET, 128, 5));
    send_item(make_item(OP_SET, 128, 5));
    send_item(make_item(OP_SET, 1, 15));
    send_item(make_item(OP_QUERY, 1, 42));
    send_item(make_item(OP_SET, 1, 16));
    send_item(make_item(OP_QUERY, 128, 0));
  endtask

  // Sketches at and beyond the limit, zero limit, oversized limit
  task automatic test_sketch_limit();
    int unsigned edge_idx;
    edge_idx = $urandom_range(255, 2);
    write_sketch_limit(CFG_W'(1));
    send_item(make_item(OP_QUERY, 0, 0));
    send_item(make_item(OP_QUERY, 1, 0));
    send_item(make_item(OP_SET, 1, 3));
    send_item(make_item(OP_SET, 0, 2));
    write_sketch_limit(CFG_W'(0));
    send_item(make_item(OP_QUERY, 0, 0));
    send_item(make_item(OP_SET, 0, 7));
    write_sketch_limit(CFG_W'(511));
    send_item(make_item(OP_SET, 255, 0));
    send_item(make_item(OP_QUERY, 200, 0));
    write_sketch_limit(CFG_W'(edge_idx));
    send_item(make_item(OP_SET, edge_idx, 9));
    send_item(make_item(OP_QUERY, edge_idx, 9));
    send_item(make_item(OP_SET, edge_idx - 1, 9));
  endtask

  // Fill whole sketches in shuffled order up to all ones
  task automatic test_fill_sketches();
    int unsigned order [SKETCH_BITS];
    int unsigned target, j, tmp, k;
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    write_sketch_limit(CFG_RESET);
    repeat (2) begin
      target = $urandom_range(255);
      for (k = 0; k < SKETCH_BITS; k++) order[k] = k;
      for (k = SKETCH_BITS - 1; k > 0; k--) begin
        j        = $urandom_range(k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      for (k = 0; k < SKETCH_BITS; k++) begin
        send_item(make_item(OP_SET, target, order[k]));
        if ($urandom_range(3) == 0) begin
          send_item(make_item(OP_QUERY, target, $urandom_range(63)));
        end
      end
      send_item(make_item(OP_SET, target, $urandom_range(31)));
    end
  endtask

  function automatic sbrs_in_t random_item(int unsigned span);
    sbrs_in_t    item;
    int unsigned pick;
    item.opcode = ($urandom_range(99) < 70) ? OP_SET : OP_QUERY;
    pick = $urandom_range(99);
    if (pick < 40) begin
      item.sketch_index = hot_sketch[$urandom_range(1)];
    end else if (pick < 75 && span != 0) begin
      item.sketch_index = SKETCH_IDX_W'($urandom_range(span - 1));
    end else begin
      item.sketch_index = SKETCH_IDX_W'($urandom_range(255));
    end
    if ($urandom_range(99) < 85) begin
      item.bit_index = BIT_IDX_W'($urandom_range(SKETCH_BITS - 1));
    end else begin
      item.bit_index = BIT_IDX_W'($urandom_range(63, SKETCH_BITS));
    end
    return item;
  endfunction

  // Random traffic under one limit and one idle and stall pattern, drained halfway
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input logic [CFG_W-1:0] limit);
    int unsigned span, n;
    write_sketch_limit(limit);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    span = (limit > NUM_SKETCHES) ? NUM_SKETCHES : limit;
    hot_sketch[0] = SKETCH_IDX_W'($urandom_range(span - 1));
    hot_sketch[1] = SKETCH_IDX_W'($urandom_range(span - 1));
    for (n = 0; n < count; n++) begin
      if (n == count / 2) wait_idle();
      send_item(random_item(span));
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_SKETCHES; i++) sketch_words[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_edges();
    test_sketch_limit();
    test_fill_sketches();
    test_random_traffic(85, 0, 0, CFG_RESET);
    test_random_traffic(85, 60, 0, CFG_W'($urandom_range(255, 2)));
    test_random_traffic(85, 0, 60, CFG_W'(511));
    test_random_traffic(85, 30, 30, CFG_RESET);
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/sbrs_pkg.sv
sv/sbrs_ram.sv
sv/sketch_bitmap_rank_store.sv
tb/sv/tb.sv
